// ===== hdl/kef_pkg.sv =====
package kef_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] idx_t;

    // Fixed frame bytes
    localparam byte_t HDR_A       = 8'h57;
    localparam byte_t HDR_B       = 8'hAB;
    localparam byte_t TYPE_BYTE   = 8'h71;
    localparam byte_t SUBTYPE_KBD = 8'h01;

    // CRC-8, poly 0x07, init 0, no reflection, no final xor
    localparam byte_t CRC_POLY   = 8'h07;
    localparam byte_t CRC_INIT   = 8'h00;
    localparam byte_t CRC_TOPBIT = 8'h80;

    // Byte positions within the frame
    localparam idx_t IDX_HDR_A   = 4'd0;
    localparam idx_t IDX_HDR_B   = 4'd1;
    localparam idx_t IDX_TYPE    = 4'd2;
    localparam idx_t IDX_SEQ     = 4'd3;
    localparam idx_t IDX_SUBTYPE = 4'd4;
    localparam idx_t IDX_USAGE   = 4'd5;
    localparam idx_t IDX_PRESSED = 4'd6;
    localparam idx_t IDX_MOD     = 4'd7;
    localparam idx_t IDX_CRC     = 4'd8;

    // One byte of CRC update: eight shift steps on the folded value
    function automatic byte_t crc8_byte(input byte_t acc, input byte_t data);
        byte_t v;
        v = acc ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((v & CRC_TOPBIT) != 8'h00) begin
                v = (v << 1) ^ CRC_POLY;
            end
            else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

// ===== hdl/key_event_frame_encoder_crc8.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// event    | evt_valid / evt_ready     | key_usage, key_pressed, modifier_bits
// frame    | frame_valid / frame_ready | frame_byte, last_byte
//
// Each event item yields nine frame items, one per cycle while frame_ready is
// held high, through the single frame output register. The next event is taken
// in the cycle its predecessor's CRC byte enters the output register.
// The CRC is built one byte per cycle, unless frame_ready stalls, as bytes two through seven go out.
// Reset clears the sequence counter and the frame/output valid flags.
// A stall on frame_ready freezes the output register and the byte counter.
module key_event_frame_encoder_crc8 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  logic [7:0]        key_usage,
    input  logic              key_pressed,
    input  logic [7:0]        modifier_bits,
    output logic              frame_valid,
    input  logic              frame_ready,
    output kef_pkg::byte_t    frame_byte,
    output logic              last_byte
);
    import kef_pkg::*;

    // Control state
    logic  active_reg, active_next;
    idx_t  idx_reg, idx_next;
    byte_t seq_count_reg, seq_count_next;
    logic  out_valid_reg, out_valid_next;

    // Payload
    byte_t usage_reg, mod_reg, frame_seq_reg, crc_reg, crc_next;
    logic  pressed_reg;
    byte_t byte_out_reg, byte_out_next;
    logic  last_out_reg, last_out_next;

    logic  advance;
    logic  load;
    byte_t cur_byte;

    // Next byte moves into the output register when it is free or being drained
    assign advance   = active_reg && (!out_valid_reg || frame_ready);
    assign evt_ready = !active_reg || (advance && idx_reg == IDX_CRC);
    assign load      = evt_valid && evt_ready;

    // Byte select for the current frame position
    always_comb
    begin
        unique case (idx_reg)
            IDX_HDR_A:   cur_byte = HDR_A;
            IDX_HDR_B:   cur_byte = HDR_B;
            IDX_TYPE:    cur_byte = TYPE_BYTE;
            IDX_SEQ:     cur_byte = frame_seq_reg;
            IDX_SUBTYPE: cur_byte = SUBTYPE_KBD;
            IDX_USAGE:   cur_byte = usage_reg;
            IDX_PRESSED: cur_byte = {7'd0, pressed_reg};
            IDX_MOD:     cur_byte = mod_reg;
            default:     cur_byte = crc_reg;
        endcase
    end

    // Sequencing, CRC accumulation and output register
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        seq_count_next = seq_count_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        byte_out_next  = byte_out_reg;
        last_out_next  = last_out_reg;

        if (frame_ready) begin
            out_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = 1'b1;
            byte_out_next  = cur_byte;
            last_out_next  = (idx_reg == IDX_CRC);
            if (idx_reg >= IDX_TYPE && idx_reg <= IDX_MOD) begin
                crc_next = crc8_byte(crc_reg, cur_byte);
            end
            if (idx_reg == IDX_CRC) begin
                active_next = 1'b0;
            end
            else begin
                idx_next = idx_reg + 4'd1;
            end
        end

        if (load) begin
            active_next    = 1'b1;
            idx_next       = IDX_HDR_A;
            crc_next       = CRC_INIT;
            seq_count_next = seq_count_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            idx_reg       <= IDX_HDR_A;
            seq_count_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            seq_count_reg <= seq_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Event capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (load) begin
            usage_reg     <= key_usage;
            pressed_reg   <= key_pressed;
            mod_reg       <= modifier_bits;
            frame_seq_reg <= seq_count_reg;
        end
        crc_reg      <= crc_next;
        byte_out_reg <= byte_out_next;
        last_out_reg <= last_out_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame_byte  = byte_out_reg;
    assign last_byte   = last_out_reg;

endmodule

// ===== hdl/kef_checker.sv =====
module kef_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           evt_valid,
    input logic           evt_ready,
    input logic           frame_valid,
    input logic           frame_ready,
    input kef_pkg::byte_t frame_byte,
    input logic           last_byte
);
    import kef_pkg::*;

    // A stalled frame item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=>
            frame_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("frame item changed while stalled");

    // An accepted event always shows output, through the active flag and then the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |-> ##2 frame_valid)
        else $error("no frame item after event accept");

    // Inside a frame the bytes follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && !last_byte |=> frame_valid)
        else $error("gap inside a frame");

    // After a CRC byte the next item starts a new frame header
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && last_byte |=>
            !frame_valid || (frame_byte == HDR_A && !last_byte))
        else $error("frame did not restart at header");

endmodule

bind key_event_frame_encoder_crc8 kef_checker u_kef_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt_valid),
    .evt_ready   (evt_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
);

// ===== tb/sv/key_event_frame_encoder_crc8_tb.sv =====
module key_event_frame_encoder_crc8_tb;

    import kef_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] usage;
        logic       pressed;
        logic [7:0] mods;
    } key_event_t;

    typedef struct {
        byte_t data;
        logic  last;
    } frame_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       evt_valid = 1'b0;
    logic       evt_ready;
    logic [7:0] key_usage = 8'h00;
    logic       key_pressed = 1'b0;
    logic [7:0] modifier_bits = 8'h00;
    logic       frame_valid;
    logic       frame_ready = 1'b0;
    byte_t      frame_byte;
    logic       last_byte;

    key_event_t  key_event_q[$];
    frame_beat_t frame_beat_q[$];
    key_event_t  cur_evt;
    byte_t       seq_num = 8'h00;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          err_cnt = 0;
    int          events_sent = 0;
    int          bytes_checked = 0;
    int          seq_wraps = 0;
    int          stall_cnt = 0;

    key_event_frame_encoder_crc8 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt_valid     (evt_valid),
        .evt_ready     (evt_ready),
        .key_usage     (key_usage),
        .key_pressed   (key_pressed),
        .modifier_bits (modifier_bits),
        .frame_valid   (frame_valid),
        .frame_ready   (frame_ready),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bit-serial CRC-8, MSB first: feedback is top CRC bit xor data bit
    function automatic byte_t crc8_serial(input byte_t crc, input byte_t data);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[7] ^ data[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    // Expected nine-byte frame for one accepted key event
    task automatic queue_key_frame(input key_event_t ev);
        byte_t bytes[9];
        byte_t crc;
        bytes[IDX_HDR_A]   = HDR_A;
        bytes[IDX_HDR_B]   = HDR_B;
        bytes[IDX_TYPE]    = TYPE_BYTE;
        bytes[IDX_SEQ]     = seq_num;
        bytes[IDX_SUBTYPE] = SUBTYPE_KBD;
        bytes[IDX_USAGE]   = ev.usage;
        bytes[IDX_PRESSED] = {7'b0, ev.pressed};
        bytes[IDX_MOD]     = ev.mods;
        crc = CRC_INIT;
        for (int i = IDX_TYPE; i <= IDX_MOD; i++)
        begin
            crc = crc8_serial(crc, bytes[i]);
        end
        bytes[IDX_CRC] = crc;
        for (int k = 0; k < 9; k++)
        begin
            frame_beat_q.push_back('{data: bytes[k], last: (k == IDX_CRC)});
        end
        if (seq_num == 8'hFF)
        begin
            seq_wraps++;
        end
        seq_num = seq_num + 8'd1;
    endtask

    task automatic add_event(input logic [7:0] usage, input logic pressed,
                             input logic [7:0] mods);
        key_event_q.push_back('{usage: usage, pressed: pressed, mods: mods});
    endtask

    task automatic add_random_events(input int count);
        for (int i = 0; i < count; i++)
        begin
            add_event(8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (key_event_q.size() != 0 || evt_valid || frame_beat_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Event driver: predicts on acceptance, then offers the next queued item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            if (evt_valid && evt_ready)
            begin
                queue_key_frame(cur_evt);
                events_sent++;
            end
            if (!evt_valid || evt_ready)
            begin
                if (key_event_q.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    cur_evt = key_event_q.pop_front();
                    evt_valid     <= 1'b1;
                    key_usage     <= cur_evt.usage;
                    key_pressed   <= cur_evt.pressed;
                    modifier_bits <= cur_evt.mods;
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    // Frame receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
        end
        else
        begin
            frame_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Frame monitor: compare each accepted byte with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && frame_ready)
        begin
            if (frame_beat_q.size() == 0)
            begin
                $display("%0t: unexpected frame item, byte %02h last %0b",
                         $time, frame_byte, last_byte);
                err_cnt++;
            end
            else
            begin
                frame_beat_t exp_beat;
                exp_beat = frame_beat_q.pop_front();
                bytes_checked++;
                if (frame_byte !== exp_beat.data)
                begin
                    $display("%0t: frame_byte expected %02h got %02h",
                             $time, exp_beat.data, frame_byte);
                    err_cnt++;
                end
                if (last_byte !== exp_beat.last)
                begin
                    $display("%0t: last_byte expected %0b got %0b",
                             $time, exp_beat.last, last_byte);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && evt_ready) || (frame_valid && frame_ready))
            begin
                stall_cnt <= 0;
            end
            else
            begin
                stall_cnt <= stall_cnt + 1;
            end
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: timeout, %0d frame bytes outstanding",
                         $time, frame_beat_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, both key states, single modifier bits
        add_event(8'h00, 1'b0, 8'h00);
        add_event(8'hFF, 1'b1, 8'hFF);
        add_event(8'hFF, 1'b0, 8'h00);
        add_event(8'h00, 1'b1, 8'hFF);
        add_event(8'h04, 1'b1, 8'h01);
        add_event(8'h04, 1'b0, 8'h80);
        add_event(8'h80, 1'b1, 8'h02);
        add_event(8'h01, 1'b0, 8'h40);
        add_event(8'h55, 1'b1, 8'hAA);
        add_event(8'hAA, 1'b0, 8'h55);
        add_event(8'h71, 1'b1, 8'h07);
        add_event(8'hE0, 1'b1, 8'h10);

        // Sender idles lightly, receiver stalls heavily
        @(negedge clk);
        snd_idle_pct = 21;
        rcv_idle_pct = 88;
        add_random_events(80);
        wait_drained();

        // Roles swapped
        snd_idle_pct = 88;
        rcv_idle_pct = 21;
        add_random_events(85);
        wait_drained();

        // Full rate on both sides; pushes the sequence number past a wrap
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        add_random_events(95);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d key events and checked %0d frame bytes;", events_sent,
                 bytes_checked);
        $display("sequence number wrapped %0d time(s) under three stall mixes.",
                 seq_wraps);
        if (err_cnt == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kef_pkg.sv
hdl/key_event_frame_encoder_crc8.sv
hdl/kef_checker.sv
tb/sv/key_event_frame_encoder_crc8_tb.sv
